/* src/crs_pkg.sv */
package crs_pkg;

    localparam int TIME_W     = 40;
    localparam int YEAR_W     = 16;
    localparam int DAYS_W     = 26;
    localparam int SUB_W      = 41;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int YEAR_SPAN  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SECOND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MONTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DOM_STAR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DOW_STAR = 3'd7;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_SEC = 3'd0;
    localparam logic [OP_W-1:0] OP_MIN = 3'd1;
    localparam logic [OP_W-1:0] OP_HR  = 3'd2;
    localparam logic [OP_W-1:0] OP_DAY = 3'd3;
    localparam logic [OP_W-1:0] OP_MON = 3'd4;

    // seconds from 1 March of year 0 to the epoch, and per era, year and unit
    localparam logic [SUB_W-1:0] EPOCH_SEC = 41'd62162035200;
    localparam logic [SUB_W-1:0] ERA_SEC   = 41'd12622780800;
    localparam logic [SUB_W-1:0] YEAR_SEC  = 41'd31536000;
    localparam logic [SUB_W-1:0] LEAP_SEC  = 41'd31622400;
    localparam logic [SUB_W-1:0] DAY_SEC   = 41'd86400;
    localparam logic [SUB_W-1:0] HOUR_SEC  = 41'd3600;
    localparam logic [SUB_W-1:0] MIN_SEC   = 41'd60;

    // 1 March of year 0 is day -719468 and a Wednesday
    localparam logic signed [DAYS_W-1:0] ERA_BASE_DAYS = -26'sd719468;
    localparam logic [DAYS_W-1:0]        ERA_DAYS      = 26'd146097;
    localparam logic [2:0]               ERA_BASE_WDAY = 3'd3;

    typedef struct packed {
        logic [YEAR_W-1:0]        y;
        logic [1:0]               y4;
        logic [6:0]               y100;
        logic [8:0]               y400;
        logic [3:0]               mo;
        logic [4:0]               d;
        logic [4:0]               h;
        logic [5:0]               mi;
        logic [5:0]               se;
        logic signed [DAYS_W-1:0] days;
        logic [2:0]               w;
    } t_civil;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            prev;
    } t_step_ctl;

    function automatic logic is_leap(input t_civil c);
        return (c.y4 == 2'd0 && c.y100 != 7'd0) || (c.y400 == 9'd0);
    endfunction

    function automatic t_civil year_inc(input t_civil c);
        t_civil r;
        r      = c;
        r.y    = c.y + 16'd1;
        r.y4   = c.y4 + 2'd1;
        r.y100 = (c.y100 == 7'd99) ? 7'd0 : c.y100 + 7'd1;
        r.y400 = (c.y400 == 9'd399) ? 9'd0 : c.y400 + 9'd1;
        return r;
    endfunction

    function automatic t_civil year_dec(input t_civil c);
        t_civil r;
        r      = c;
        r.y    = c.y - 16'd1;
        r.y4   = c.y4 - 2'd1;
        r.y100 = (c.y100 == 7'd0) ? 7'd99 : c.y100 - 7'd1;
        r.y400 = (c.y400 == 9'd0) ? 9'd399 : c.y400 - 9'd1;
        return r;
    endfunction

    function automatic logic [4:0] month_days(input logic leap, input logic [3:0] mo);
        logic [4:0] r;
        r = 5'd31;
        if (mo == 4'd2) begin
            r = leap ? 5'd29 : 5'd28;
        end else if (mo == 4'd4 || mo == 4'd6 || mo == 4'd9 || mo == 4'd11) begin
            r = 5'd30;
        end
        return r;
    endfunction

    function automatic logic [SUB_W-1:0] month_sec(input logic [4:0] n);
        logic [SUB_W-1:0] r;
        r = 41'd2678400;
        if (n == 5'd28) begin
            r = 41'd2419200;
        end else if (n == 5'd29) begin
            r = 41'd2505600;
        end else if (n == 5'd30) begin
            r = 41'd2592000;
        end
        return r;
    endfunction

    function automatic logic [2:0] mod7(input logic [5:0] v);
        logic [5:0] r;
        r = v;
        if (r >= 6'd56) r = r - 6'd56;
        if (r >= 6'd28) r = r - 6'd28;
        if (r >= 6'd14) r = r - 6'd14;
        if (r >= 6'd7)  r = r - 6'd7;
        return r[2:0];
    endfunction

endpackage

/* src/crs_div.sv */
module crs_div
    import crs_pkg::*;
(
    input  logic [SUB_W-1:0] i_num,
    input  logic [SUB_W-1:0] i_den,
    output logic             o_ge,
    output logic [SUB_W-1:0] o_diff
);

    // one step of division by repeated subtraction
    assign o_ge   = i_num >= i_den;
    assign o_diff = i_num - i_den;

endmodule

/* src/crs_step.sv */
module crs_step
    import crs_pkg::*;
(
    input  t_civil    i_civ,
    input  t_step_ctl i_ctl,
    output t_civil    o_civ,
    output logic      o_restart
);

    t_civil     c;
    logic       lp;
    logic [4:0] dm;
    logic [4:0] dprev;
    logic       cm;
    logic       ch;
    logic       cd;
    logic       cmo;
    logic       mwrap;
    logic [5:0] delta;

    always_comb begin
        c     = i_civ;
        lp    = is_leap(i_civ);
        dm    = month_days(lp, i_civ.mo);
        dprev = month_days(lp, i_civ.mo - 4'd1);
        cm    = 1'b0;
        ch    = 1'b0;
        cd    = 1'b0;
        cmo   = 1'b0;
        mwrap = 1'b0;
        delta = {1'b0, dm} - {1'b0, i_civ.d} + 6'd1;
        if (!i_ctl.prev) begin
            unique case (i_ctl.op)
                OP_SEC: begin
                    cm   = i_civ.se == 6'd59;
                    c.se = cm ? 6'd0 : i_civ.se + 6'd1;
                end
                OP_MIN: begin
                    c.se = 6'd0;
                    cm   = 1'b1;
                end
                OP_HR: begin
                    c.mi = 6'd0;
                    c.se = 6'd0;
                    ch   = 1'b1;
                end
                OP_DAY: begin
                    c.h  = 5'd0;
                    c.mi = 6'd0;
                    c.se = 6'd0;
                    cd   = 1'b1;
                end
                OP_MON: begin
                    // jump to the first of the next month
                    c.days = i_civ.days + {{(DAYS_W-6){1'b0}}, delta};
                    c.w    = mod7({3'd0, i_civ.w} + delta);
                    c.d    = 5'd1;
                    c.h    = 5'd0;
                    c.mi   = 6'd0;
                    c.se   = 6'd0;
                    mwrap  = i_civ.mo == 4'd12;
                    if (mwrap) begin
                        c.mo = 4'd1;
                        c    = year_inc(c);
                    end else begin
                        c.mo = i_civ.mo + 4'd1;
                    end
                end
                default: ;
            endcase
            if (cm) begin
                ch   = i_civ.mi == 6'd59;
                c.mi = ch ? 6'd0 : i_civ.mi + 6'd1;
            end
            if (ch) begin
                cd  = i_civ.h == 5'd23;
                c.h = cd ? 5'd0 : i_civ.h + 5'd1;
            end
            if (cd) begin
                c.days = i_civ.days + 26'sd1;
                c.w    = (i_civ.w == 3'd6) ? 3'd0 : i_civ.w + 3'd1;
                cmo    = i_civ.d >= dm;
                if (cmo) begin
                    c.d = 5'd1;
                    if (i_civ.mo == 4'd12) begin
                        c.mo = 4'd1;
                        c    = year_inc(c);
                    end else begin
                        c.mo = i_civ.mo + 4'd1;
                    end
                end else begin
                    c.d = i_civ.d + 5'd1;
                end
            end
        end else begin
            unique case (i_ctl.op)
                OP_SEC: begin
                    cm   = i_civ.se == 6'd0;
                    c.se = cm ? 6'd59 : i_civ.se - 6'd1;
                end
                OP_MIN: begin
                    c.se = 6'd59;
                    cm   = 1'b1;
                end
                OP_HR: begin
                    c.mi = 6'd59;
                    c.se = 6'd59;
                    ch   = 1'b1;
                end
                OP_DAY: begin
                    c.h  = 5'd23;
                    c.mi = 6'd59;
                    c.se = 6'd59;
                    cd   = 1'b1;
                end
                OP_MON: begin
                    // drop back to the last day of the previous month
                    c.days = i_civ.days - {{(DAYS_W-5){1'b0}}, i_civ.d};
                    c.w    = mod7(6'd35 - {1'b0, i_civ.d} + {3'd0, i_civ.w});
                    c.h    = 5'd23;
                    c.mi   = 6'd59;
                    c.se   = 6'd59;
                    mwrap  = i_civ.mo == 4'd1;
                    if (mwrap) begin
                        c.mo = 4'd12;
                        c.d  = 5'd31;
                        c    = year_dec(c);
                    end else begin
                        c.mo = i_civ.mo - 4'd1;
                        c.d  = dprev;
                    end
                end
                default: ;
            endcase
            if (cm) begin
                ch   = i_civ.mi == 6'd0;
                c.mi = ch ? 6'd59 : i_civ.mi - 6'd1;
            end
            if (ch) begin
                cd  = i_civ.h == 5'd0;
                c.h = cd ? 5'd23 : i_civ.h - 5'd1;
            end
            if (cd) begin
                c.days = i_civ.days - 26'sd1;
                c.w    = (i_civ.w == 3'd0) ? 3'd6 : i_civ.w - 3'd1;
                cmo    = i_civ.d <= 5'd1;
                if (cmo) begin
                    if (i_civ.mo == 4'd1) begin
                        c.mo = 4'd12;
                        c.d  = 5'd31;
                        c    = year_dec(c);
                    end else begin
                        c.mo = i_civ.mo - 4'd1;
                        c.d  = dprev;
                    end
                end else begin
                    c.d = i_civ.d - 5'd1;
                end
            end
        end
    end

    always_comb begin
        unique case (i_ctl.op)
            OP_SEC:  o_restart = cm;
            OP_MIN:  o_restart = ch;
            OP_HR:   o_restart = cd;
            OP_DAY:  o_restart = cmo;
            OP_MON:  o_restart = mwrap;
            default: o_restart = 1'b0;
        endcase
    end

    assign o_civ = c;

endmodule

/* src/cron_schedule_time_search_unit.sv */
// Channel  Direction  Handshake                Word
// in       input      i_in_valid/o_in_stall    i_kind, i_time_in
// out      output     o_out_valid/i_out_stall  o_found, o_time_out
// cfg      input      i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// One search at a time. Conversion peels off eras, years, months, days, hours and
// minutes through one shared compare-and-subtract unit, one step a cycle: at most
// 92 eras, 399 years, 11 months, 30 days, 23 hours and 59 minutes, each with an exit.
// The search then makes one field check or step a cycle, so a day scan steps one day
// at a time; S_MUL and S_SUM build the result, and S_DONE hands it over.
// Reset is synchronous and clears the mask registers and the control state.
// A finished word waits in the output register; a new word is taken meanwhile.
module cron_schedule_time_search_unit
    import crs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_kind,
    input  logic [TIME_W-1:0]     i_time_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_found,
    output logic [TIME_W-1:0]     o_time_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ERA   = 5'd1;
    localparam logic [4:0] S_YEAR  = 5'd2;
    localparam logic [4:0] S_MONTH = 5'd3;
    localparam logic [4:0] S_DAYS  = 5'd4;
    localparam logic [4:0] S_HRS   = 5'd5;
    localparam logic [4:0] S_MINS  = 5'd6;
    localparam logic [4:0] S_PREP  = 5'd7;
    localparam logic [4:0] S_LIM   = 5'd8;
    localparam logic [4:0] S_MON   = 5'd9;
    localparam logic [4:0] S_DAY   = 5'd10;
    localparam logic [4:0] S_HR    = 5'd11;
    localparam logic [4:0] S_MIN   = 5'd12;
    localparam logic [4:0] S_SEC   = 5'd13;
    localparam logic [4:0] S_MUL   = 5'd14;
    localparam logic [4:0] S_SUM   = 5'd15;
    localparam logic [4:0] S_DONE  = 5'd16;

    logic [59:0] r_sec_mask;
    logic [59:0] r_min_mask;
    logic [23:0] r_hr_mask;
    logic [31:0] r_dom_mask;
    logic [12:0] r_mon_mask;
    logic [6:0]  r_dow_mask;
    logic        r_dom_star;
    logic        r_dow_star;

    logic [4:0]        r_state, n_state;
    logic [SUB_W-1:0]  r_z, n_z;
    logic              r_prev, n_prev;
    t_civil            r_civ, n_civ;
    logic [YEAR_W-1:0] r_lim, n_lim;
    logic [41:0]       r_prod, n_prod;
    logic [16:0]       r_tod, n_tod;
    logic              r_found, n_found;
    logic [TIME_W-1:0] r_tout, n_tout;
    logic              r_out_valid, n_out_valid;
    logic              r_out_found, n_out_found;
    logic [TIME_W-1:0] r_out_time, n_out_time;

    logic [SUB_W-1:0] sub_den;
    logic             sub_ge;
    logic [SUB_W-1:0] sub_diff;

    t_step_ctl step_ctl;
    t_civil    step_civ;
    logic      step_restart;

    t_civil    civ_next_yr;
    logic       ny_leap;
    logic [8:0] ylen;
    logic [4:0] mlen;
    logic       day_a;
    logic       day_b;
    logic       day_hit;
    logic [41:0] t_sum;

    crs_div u_div (
        .i_num  (r_z),
        .i_den  (sub_den),
        .o_ge   (sub_ge),
        .o_diff (sub_diff)
    );

    crs_step u_step (
        .i_civ     (r_civ),
        .i_ctl     (step_ctl),
        .o_civ     (step_civ),
        .o_restart (step_restart)
    );

    always_comb begin
        unique case (r_state)
            S_ERA:   sub_den = ERA_SEC;
            S_YEAR:  sub_den = ny_leap ? LEAP_SEC : YEAR_SEC;
            S_MONTH: sub_den = month_sec(mlen);
            S_DAYS:  sub_den = DAY_SEC;
            S_HRS:   sub_den = HOUR_SEC;
            default: sub_den = MIN_SEC;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_MON:   step_ctl.op = OP_MON;
            S_DAY:   step_ctl.op = OP_DAY;
            S_HR:    step_ctl.op = OP_HR;
            S_MIN:   step_ctl.op = OP_MIN;
            default: step_ctl.op = OP_SEC;
        endcase
        step_ctl.prev = r_prev;
    end

    // civil year of Jan/Feb in a March-based year is the following one
    assign civ_next_yr = year_inc(r_civ);
    assign ny_leap = is_leap(civ_next_yr);
    assign ylen    = ny_leap ? 9'd366 : 9'd365;
    assign mlen    = month_days(ny_leap, r_civ.mo);
    assign day_a   = r_dom_mask[r_civ.d];
    assign day_b   = r_dow_mask[r_civ.w];
    assign day_hit = (r_dom_star || r_dow_star) ? (day_a && day_b) : (day_a || day_b);
    assign t_sum   = r_prod + {25'd0, r_tod};

    always_comb begin
        n_state     = r_state;
        n_z         = r_z;
        n_prev      = r_prev;
        n_civ       = r_civ;
        n_lim       = r_lim;
        n_prod      = r_prod;
        n_tod       = r_tod;
        n_found     = r_found;
        n_tout      = r_tout;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_found = r_out_found;
        n_out_time  = r_out_time;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_z        = {1'b0, i_time_in} + EPOCH_SEC;
                    n_prev     = i_kind;
                    n_civ      = '0;
                    n_civ.mo   = 4'd3;
                    n_civ.d    = 5'd1;
                    n_civ.days = ERA_BASE_DAYS;
                    n_civ.w    = ERA_BASE_WDAY;
                    n_state    = S_ERA;
                end
            end
            S_ERA: begin
                if (sub_ge) begin
                    n_z        = sub_diff;
                    n_civ.y    = r_civ.y + 16'd400;
                    n_civ.days = r_civ.days + ERA_DAYS;
                end else begin
                    n_state = S_YEAR;
                end
            end
            S_YEAR: begin
                if (sub_ge) begin
                    n_z        = sub_diff;
                    n_civ      = civ_next_yr;
                    n_civ.days = r_civ.days + {{(DAYS_W-9){1'b0}}, ylen};
                    n_civ.w    = mod7({3'd0, r_civ.w} + (ny_leap ? 6'd2 : 6'd1));
                end else begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (sub_ge) begin
                    n_z        = sub_diff;
                    n_civ.mo   = (r_civ.mo == 4'd12) ? 4'd1 : r_civ.mo + 4'd1;
                    n_civ.days = r_civ.days + {{(DAYS_W-5){1'b0}}, mlen};
                    n_civ.w    = mod7({3'd0, r_civ.w} + {1'b0, mlen} - 6'd28);
                end else begin
                    if (r_civ.mo <= 4'd2) begin
                        n_civ = civ_next_yr;
                    end
                    n_state = S_DAYS;
                end
            end
            S_DAYS: begin
                if (sub_ge) begin
                    n_z        = sub_diff;
                    n_civ.d    = r_civ.d + 5'd1;
                    n_civ.days = r_civ.days + 26'sd1;
                    n_civ.w    = (r_civ.w == 3'd6) ? 3'd0 : r_civ.w + 3'd1;
                end else begin
                    n_state = S_HRS;
                end
            end
            S_HRS: begin
                if (sub_ge) begin
                    n_z     = sub_diff;
                    n_civ.h = r_civ.h + 5'd1;
                end else begin
                    n_state = S_MINS;
                end
            end
            S_MINS: begin
                if (sub_ge) begin
                    n_z      = sub_diff;
                    n_civ.mi = r_civ.mi + 6'd1;
                end else begin
                    n_civ.se = r_z[5:0];
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                n_lim   = r_prev ? r_civ.y - 16'(YEAR_SPAN) : r_civ.y + 16'(YEAR_SPAN);
                n_state = S_LIM;
                if (r_sec_mask == '0 || r_min_mask == '0 || r_hr_mask == '0 ||
                    r_mon_mask[12:1] == '0) begin
                    n_found = 1'b0;
                    n_tout  = '0;
                    n_state = S_DONE;
                end
            end
            S_LIM: begin
                if (r_prev ? (r_civ.y < r_lim) : (r_civ.y > r_lim)) begin
                    n_found = 1'b0;
                    n_tout  = '0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_MON;
                end
            end
            S_MON, S_DAY, S_HR, S_MIN, S_SEC: begin
                if ((r_state == S_MON && r_mon_mask[r_civ.mo]) ||
                    (r_state == S_DAY && day_hit) ||
                    (r_state == S_HR  && r_hr_mask[r_civ.h]) ||
                    (r_state == S_MIN && r_min_mask[r_civ.mi]) ||
                    (r_state == S_SEC && r_sec_mask[r_civ.se])) begin
                    n_state = r_state + 5'd1;
                end else begin
                    n_civ = step_civ;
                    if (step_restart) begin
                        n_state = S_LIM;
                    end
                end
            end
            S_MUL: begin
                n_prod  = {17'd0, r_civ.days[24:0]} * 42'd86400;
                n_tod   = {12'd0, r_civ.h} * 17'd3600 + {11'd0, r_civ.mi} * 17'd60
                        + {11'd0, r_civ.se};
                n_state = S_SUM;
                if (r_civ.days[DAYS_W-1]) begin
                    n_found = 1'b0;
                    n_tout  = '0;
                    n_state = S_DONE;
                end
            end
            S_SUM: begin
                n_state = S_DONE;
                if (t_sum[41:40] != 2'd0) begin
                    n_found = 1'b0;
                    n_tout  = '0;
                end else begin
                    n_found = 1'b1;
                    n_tout  = t_sum[TIME_W-1:0];
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_time  = r_tout;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z        <= n_z;
        r_prev     <= n_prev;
        r_civ      <= n_civ;
        r_lim      <= n_lim;
        r_prod     <= n_prod;
        r_tod      <= n_tod;
        r_found    <= n_found;
        r_tout     <= n_tout;
        r_out_found <= n_out_found;
        r_out_time <= n_out_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_mask <= '0;
            r_min_mask <= '0;
            r_hr_mask  <= '0;
            r_dom_mask <= '0;
            r_mon_mask <= '0;
            r_dow_mask <= '0;
            r_dom_star <= 1'b0;
            r_dow_star <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SECOND:   r_sec_mask <= i_cfg_data[59:0];
                CFG_MINUTE:   r_min_mask <= i_cfg_data[59:0];
                CFG_HOUR:     r_hr_mask  <= i_cfg_data[23:0];
                CFG_DOM:      r_dom_mask <= i_cfg_data[31:0];
                CFG_MONTH:    r_mon_mask <= i_cfg_data[12:0];
                CFG_DOW:      r_dow_mask <= i_cfg_data[6:0];
                CFG_DOM_STAR: r_dom_star <= i_cfg_data[0];
                CFG_DOW_STAR: r_dow_star <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_time_out  = r_out_time;
    assign o_cfg_ready = 1'b1;

endmodule

/* dv/search_checker.sv */
module search_checker
    import crs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_kind,
    input  logic [TIME_W-1:0]     i_time_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_found,
    input  logic [TIME_W-1:0]     i_time_out,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_hits
);

    localparam longint TIME_TOP = 64'hFF_FFFF_FFFF;

    typedef struct {
        longint y;
        int     mo, d, h, mi, se;
    } stamp_t;

    typedef struct packed {
        logic              found;
        logic [TIME_W-1:0] t;
    } fire_t;

    logic [59:0] sec_m, min_m;
    logic [23:0] hr_m;
    logic [31:0] dom_m;
    logic [12:0] mon_m;
    logic [6:0]  dow_m;
    logic        dom_star, dow_star;
    fire_t       fire_q[$];

    function automatic bit is_leap_year(longint y);
        return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    function automatic int days_in(longint y, int mo);
        case (mo)
            2: return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic longint day_number(longint y_in, int mo, int d);
        longint y, era, yoe, mp, doy, doe;
        y   = y_in - ((mo <= 2) ? 1 : 0);
        era = ((y >= 0) ? y : y - 399) / 400;
        yoe = y - era * 400;
        mp  = (mo + 9) % 12;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic stamp_t to_stamp(longint t);
        stamp_t c;
        longint z, r, era, doe, yoe, doy, mp;
        z   = t / 86400 + 719468;
        r   = t % 86400;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        c.d  = int'(doy - (153 * mp + 2) / 5 + 1);
        c.mo = int'((mp < 10) ? mp + 3 : mp - 9);
        c.y  = yoe + era * 400 + ((c.mo <= 2) ? 1 : 0);
        c.h  = int'(r / 3600);
        c.mi = int'((r % 3600) / 60);
        c.se = int'(r % 60);
        return c;
    endfunction

    function automatic bit day_allowed(stamp_t c);
        longint days;
        int     w;
        bit     a, b;
        days = day_number(c.y, c.mo, c.d);
        w    = int'(((days % 7) + 7 + 4) % 7);
        a    = dom_m[c.d];
        b    = dow_m[w];
        if (dom_star || dow_star) return a && b;
        return a || b;
    endfunction

    // true when the month rolled
    function automatic bit day_fwd(inout stamp_t c);
        c.d++;
        if (c.d > days_in(c.y, c.mo)) begin
            c.d = 1;
            c.mo++;
            if (c.mo > 12) begin
                c.mo = 1;
                c.y++;
            end
            return 1;
        end
        return 0;
    endfunction

    function automatic void hour_fwd(inout stamp_t c);
        bit rolled;
        c.h++;
        if (c.h > 23) begin
            c.h = 0;
            rolled = day_fwd(c);
        end
    endfunction

    function automatic void minute_fwd(inout stamp_t c);
        c.mi++;
        if (c.mi > 59) begin
            c.mi = 0;
            hour_fwd(c);
        end
    endfunction

    function automatic bit day_back(inout stamp_t c);
        c.d--;
        if (c.d < 1) begin
            c.mo--;
            if (c.mo < 1) begin
                c.mo = 12;
                c.y--;
            end
            c.d = days_in(c.y, c.mo);
            return 1;
        end
        return 0;
    endfunction

    function automatic void hour_back(inout stamp_t c);
        bit rolled;
        c.h--;
        if (c.h < 0) begin
            c.h = 23;
            rolled = day_back(c);
        end
    endfunction

    function automatic void minute_back(inout stamp_t c);
        c.mi--;
        if (c.mi < 0) begin
            c.mi = 59;
            hour_back(c);
        end
    endfunction

    function automatic bit seek_next(inout stamp_t c);
        longint lim;
        bit     again;
        lim = c.y + YEAR_SPAN;
        while (1) begin
            again = 0;
            if (c.y > lim) return 0;
            while (!mon_m[c.mo]) begin
                c.d = 1; c.h = 0; c.mi = 0; c.se = 0;
                c.mo++;
                if (c.mo > 12) begin
                    c.mo = 1;
                    c.y++;
                    again = 1;
                    break;
                end
            end
            if (again) continue;
            while (!day_allowed(c)) begin
                c.h = 0; c.mi = 0; c.se = 0;
                if (day_fwd(c)) begin
                    again = 1;
                    break;
                end
            end
            if (again) continue;
            while (!hr_m[c.h]) begin
                c.mi = 0; c.se = 0;
                hour_fwd(c);
                if (c.h == 0) begin
                    again = 1;
                    break;
                end
            end
            if (again) continue;
            while (!min_m[c.mi]) begin
                c.se = 0;
                minute_fwd(c);
                if (c.mi == 0) begin
                    again = 1;
                    break;
                end
            end
            if (again) continue;
            while (!sec_m[c.se]) begin
                c.se++;
                if (c.se > 59) begin
                    c.se = 0;
                    minute_fwd(c);
                    again = 1;
                    break;
                end
            end
            if (!again) return 1;
        end
    endfunction

    function automatic bit seek_prev(inout stamp_t c);
        longint lim;
        bit     again;
        lim = c.y - YEAR_SPAN;
        while (1) begin
            again = 0;
            if (c.y < lim) return 0;
            while (!mon_m[c.mo]) begin
                c.h = 23; c.mi = 59; c.se = 59;
                c.mo--;
                if (c.mo < 1) begin
                    c.mo = 12;
                    c.y--;
                    c.d = days_in(c.y, c.mo);
                    again = 1;
                    break;
                end
                c.d = days_in(c.y, c.mo);
            end
            if (again) continue;
            while (!day_allowed(c)) begin
                c.h = 23; c.mi = 59; c.se = 59;
                if (day_back(c)) begin
                    again = 1;
                    break;
                end
            end
            if (again) continue;
            while (!hr_m[c.h]) begin
                c.mi = 59; c.se = 59;
                hour_back(c);
                if (c.h == 23) begin
                    again = 1;
                    break;
                end
            end
            if (again) continue;
            while (!min_m[c.mi]) begin
                c.se = 59;
                minute_back(c);
                if (c.mi == 59) begin
                    again = 1;
                    break;
                end
            end
            if (again) continue;
            while (!sec_m[c.se]) begin
                c.se--;
                if (c.se < 0) begin
                    c.se = 59;
                    minute_back(c);
                    again = 1;
                    break;
                end
            end
            if (!again) return 1;
        end
    endfunction

    function automatic fire_t fire_time(logic kind, logic [TIME_W-1:0] t_in);
        fire_t  r;
        stamp_t c;
        bit     ok;
        longint t;
        r = '0;
        // an empty field can never match
        if (sec_m == 0 || min_m == 0 || hr_m == 0 || mon_m[12:1] == 0) return r;
        c  = to_stamp(longint'({24'd0, t_in}));
        ok = kind ? seek_prev(c) : seek_next(c);
        if (!ok) return r;
        t = day_number(c.y, c.mo, c.d) * 86400 + c.h * 3600 + c.mi * 60 + c.se;
        if (t < 0 || t > TIME_TOP) return r;
        r.found = 1'b1;
        r.t     = t[TIME_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        fire_t exp_w;
        if (!i_rst_n) begin
            sec_m <= '0; min_m <= '0; hr_m <= '0; dom_m <= '0;
            mon_m <= '0; dow_m <= '0; dom_star <= 1'b0; dow_star <= 1'b0;
            fire_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
            o_hits    <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SECOND:   sec_m    <= i_cfg_data[59:0];
                    CFG_MINUTE:   min_m    <= i_cfg_data[59:0];
                    CFG_HOUR:     hr_m     <= i_cfg_data[23:0];
                    CFG_DOM:      dom_m    <= i_cfg_data[31:0];
                    CFG_MONTH:    mon_m    <= i_cfg_data[12:0];
                    CFG_DOW:      dow_m    <= i_cfg_data[6:0];
                    CFG_DOM_STAR: dom_star <= i_cfg_data[0];
                    CFG_DOW_STAR: dow_star <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) fire_q.push_back(fire_time(i_kind, i_time_in));
            if (i_out_valid && !i_out_stall) begin
                if (fire_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("mismatch: unexpected word found=%0d time=%0d",
                                 i_found, i_time_out);
                end else begin
                    exp_w = fire_q.pop_front();
                    if (exp_w.found)
                        o_hits <= o_hits + 1;
                    if (i_found !== exp_w.found || i_time_out !== exp_w.t) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch: exp found=%0d time=%0d, got found=%0d time=%0d",
                                     exp_w.found, exp_w.t, i_found, i_time_out);
                    end
                end
            end
            o_pending <= fire_q.size();
        end
    end

endmodule

/* dv/testbench.sv */
module testbench;
    import crs_pkg::*;

    localparam int IDLE_LIMIT = 60000;
    localparam logic [63:0] ONES = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_kind = 1'b0;
    logic [TIME_W-1:0]     i_time_in = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b1;
    logic                  o_found;
    logic [TIME_W-1:0]     o_time_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int errors, pending, hits;
    int queries_sent = 0;
    int words_taken = 0;
    int settings_used = 0;
    int idle_cycles = 0;
    bit burst = 1'b0;

    always #5 i_clk = ~i_clk;

    cron_schedule_time_search_unit uut (.*);

    search_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_kind(i_kind), .i_time_in(i_time_in),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_found(o_found), .i_time_out(o_time_out),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_hits(hits)
    );

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off to back the block up
    initial begin
        int wait_n;
        @(posedge i_rst_n);
        forever begin
            wait_n = burst ? 0 : $urandom_range(0, 9);
            if (words_taken == 30) wait_n = 3000;
            repeat (wait_n) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
            @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            words_taken++;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // drop valid first so the last word is not taken again
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0 || o_out_valid) @(posedge i_clk);
    endtask

    task automatic set_masks(input logic [63:0] sec, mn, hr, dom, mon, dow,
                             input logic ds, ws);
        drain();
        cfg_write(CFG_SECOND, sec);
        cfg_write(CFG_MINUTE, mn);
        cfg_write(CFG_HOUR, hr);
        cfg_write(CFG_DOM, dom);
        cfg_write(CFG_MONTH, mon);
        cfg_write(CFG_DOW, dow);
        cfg_write(CFG_DOM_STAR, {63'd0, ds});
        cfg_write(CFG_DOW_STAR, {63'd0, ws});
        settings_used++;
    endtask

    task automatic ask(input logic kind, input logic [TIME_W-1:0] t);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_kind     = kind;
        i_time_in  = t;
        do @(posedge i_clk); while (o_in_stall);
        queries_sent++;
    endtask

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 3))
            0: return {8'($urandom_range(0, 255)), $urandom};
            1: return {8'd0, $urandom};
            2: return TIME_W'($urandom_range(0, 200000));
            default: return ONES[TIME_W-1:0] - TIME_W'($urandom_range(0, 100000000));
        endcase
    endfunction

    function automatic logic [63:0] pick_mask(input int width);
        logic [63:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: m = ONES;
            1: ;
            2: m = 64'd1 << $urandom_range(0, width - 1);
            3: m = m & {$urandom, $urandom} & {$urandom, $urandom};
            default: m = m | {$urandom, $urandom};
        endcase
        return m;
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // masks still clear after reset: nothing can match
        ask(1'b0, 40'd1709164800);
        ask(1'b1, 40'd0);

        // every field a wildcard, junk in the unused bits: result is the start
        set_masks(ONES, ONES, ONES, ONES, ONES, ONES, 1'b1, 1'b1);
        ask(1'b0, '0);
        ask(1'b1, '0);
        ask(1'b0, ONES[TIME_W-1:0]);
        ask(1'b1, ONES[TIME_W-1:0]);

        // Feb 29 only, AND rule: lands in a leap year or runs out of years
        set_masks(64'd1, 64'd1, 64'd1, 64'd1 << 29, 64'd1 << 2, 64'h7F, 1'b0, 1'b1);
        ask(1'b0, 40'd1709164800);
        ask(1'b0, 40'd1709164801);
        ask(1'b1, 40'd1709164799);
        ask(1'b0, 40'd4107542400);
        ask(1'b1, 40'd4107542400);

        // 13th or Friday (OR rule); starts near the ends of the time range
        set_masks(64'd1 << 59, 64'd1 << 30, 64'd1 << 23, 64'd1 << 13, 64'h1FFE,
                  64'd1 << 5, 1'b0, 1'b0);
        ask(1'b0, 40'd1726185600);
        ask(1'b1, 40'd1726185600);
        ask(1'b1, 40'd100);
        ask(1'b0, ONES[TIME_W-1:0] - 40'd5);
        ask(1'b1, ONES[TIME_W-1:0]);

        // only the unused day and month bits: empty month field
        set_masks(ONES, ONES, ONES, 64'd1, 64'd1, 64'd0, 1'b0, 1'b0);
        ask(1'b0, 40'd12345678);
        ask(1'b1, 40'd12345678);

        for (int ph = 0; ph < 5; ph++) begin
            set_masks(pick_mask(60), pick_mask(60), pick_mask(24), pick_mask(32),
                      pick_mask(13) | (64'd1 << $urandom_range(1, 12)), pick_mask(7),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            for (int k = 0; k < 24; k++) begin
                burst = (k >= 8 && k < 14);
                ask(1'($urandom_range(0, 1)), pick_time());
            end
            burst = 1'b0;
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("%0d schedule queries over %0d mask settings, %0d fire times found",
                 queries_sent, settings_used, hits);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
